FILE: rtl/core/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg
// shared types, codes and defaults of the multilevel priority fifo
// ----------------------------------------------------------------------------
package mlpf_pkg;

  localparam int DEF_NUM_LEVELS  = 10;
  localparam int DEF_LEVEL_DEPTH = 16;

  localparam int OP_W    = 2;
  localparam int PRI_W   = 4;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 4;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPRI = 2'd3;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [PRI_W-1:0]          qidx;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [LEVEL_W-1:0]        level;
    logic signed [DATA_W-1:0]  result_value;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

FILE: rtl/core/mlpf_if.sv
// ----------------------------------------------------------------------------
// mlpf channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mlpf_in_if
  import mlpf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [PRI_W-1:0]         priority_req;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, priority_req, value, input ready);
  modport sink   (input valid, op, priority_req, value, output ready);
endinterface

interface mlpf_out_if
  import mlpf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [LEVEL_W-1:0]       level;
  logic signed [DATA_W-1:0] result_value;

  modport source (output valid, status, level, result_value, input ready);
  modport sink   (input valid, status, level, result_value, output ready);
endinterface

FILE: rtl/core/mlpf_ram.sv
// ----------------------------------------------------------------------------
// mlpf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mlpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mlpf_front.sv
// ----------------------------------------------------------------------------
// mlpf_front
// accepts request words and classifies them into queue commands
// ----------------------------------------------------------------------------
module mlpf_front
  import mlpf_pkg::*;
#(
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  mlpf_in_if.sink in_ch,
  output logic    q_wr_valid,
  output cmd_t    q_wr_data,
  input  logic    q_wr_ready
);

  cmd_kind_t kind;

  always_comb begin
    case (in_ch.op)
      OP_PUSH: begin
        if (int'(in_ch.priority_req) inside {[1:NUM_LEVELS]}) begin
          kind = CMD_PUSH;
        end else begin
          kind = CMD_BAD;
        end
      end
      OP_POP:  kind = CMD_POP;
      OP_PEEK: kind = CMD_PEEK;
      default: kind = CMD_BAD;
    endcase
  end

  assign q_wr_valid      = in_ch.valid;
  assign in_ch.ready     = q_wr_ready;
  assign q_wr_data.kind  = kind;
  assign q_wr_data.qidx  = in_ch.priority_req - PRI_W'(1);
  assign q_wr_data.value = in_ch.value;

endmodule

FILE: rtl/core/mlpf_cmdq.sv
// ----------------------------------------------------------------------------
// mlpf_cmdq
// two entry command queue between front and back
// ----------------------------------------------------------------------------
module mlpf_cmdq
  import mlpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  cmd_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_data,
  input  logic rd_ready
);

  localparam logic [1:0] QFULL = 2'd2;

  cmd_t       entry_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (cnt_r != QFULL);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = entry_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wptr_r <= ~wptr_r;
      end
      if (do_rd) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/mlpf_back.sv
// ----------------------------------------------------------------------------
// mlpf_back
// per level pointers and counts, entry ram, priority select and result word
// ----------------------------------------------------------------------------
module mlpf_back
  import mlpf_pkg::*;
#(
  parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  mlpf_out_if.source  out_ch
);

  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int RAM_D = NUM_LEVELS * (1 << PW);

  localparam logic [CW-1:0] CNT_FULL = CW'(LEVEL_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(LEVEL_DEPTH - 1);

  logic [CW-1:0] cnt_r  [NUM_LEVELS];
  logic [PW-1:0] head_r [NUM_LEVELS];
  logic [PW-1:0] tail_r [NUM_LEVELS];

  back_state_t        st_r;
  back_state_t        st_nxt;
  logic               out_valid_r;
  res_t               out_r;
  logic [LEVEL_W-1:0] lvl_r;

  logic          hi_found;
  logic [LW-1:0] hi_idx;
  logic [LW-1:0] sel_q;
  logic [CW-1:0] cnt_sel;
  logic [PW-1:0] head_sel;
  logic [PW-1:0] tail_sel;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic          out_free;
  logic          go;
  logic          issue_rd;
  logic          push_ok;
  logic          pop_ok;
  logic          load_out;
  res_t          res;
  logic [DATA_W-1:0] rd_data;

  always_comb begin
    hi_found = 1'b0;
    hi_idx   = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        hi_found = 1'b1;
        hi_idx   = LW'(i);
      end
    end
  end

  assign sel_q    = (cmd.kind == CMD_PUSH) ? cmd.qidx[LW-1:0] : hi_idx;
  assign cnt_sel  = cnt_r[sel_q];
  assign head_sel = head_r[sel_q];
  assign tail_sel = tail_r[sel_q];
  assign head_inc = (head_sel == PTR_LAST) ? '0 : head_sel + PW'(1);
  assign tail_inc = (tail_sel == PTR_LAST) ? '0 : tail_sel + PW'(1);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    case (st_r)
      BK_IDLE: st_nxt = issue_rd ? BK_READ : BK_IDLE;
      BK_READ: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    go       = 1'b0;
    issue_rd = 1'b0;
    push_ok  = 1'b0;
    pop_ok   = 1'b0;
    load_out = 1'b0;
    res      = '{status: ST_OK, level: '0, result_value: '0};
    case (st_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          go = 1'b1;
          case (cmd.kind)
            CMD_PUSH: begin
              if (cnt_sel == CNT_FULL) begin
                res.status = ST_FULL;
              end else begin
                push_ok = 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (!hi_found) begin
                res.status = ST_EMPTY;
              end else begin
                issue_rd = 1'b1;
                pop_ok   = (cmd.kind == CMD_POP);
              end
            end
            default: res.status = ST_BADPRI;
          endcase
          load_out = !issue_rd;
        end
      end
      BK_READ: begin
        load_out         = 1'b1;
        res.level        = lvl_r;
        res.result_value = rd_data;
      end
      default: ;
    endcase
  end

  assign cmd_ready = go;

  mlpf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr ({sel_q, tail_sel}),
    .wdata (cmd.value),
    .re    (issue_rd),
    .raddr ({sel_q, head_sel}),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (push_ok) begin
        tail_r[sel_q] <= tail_inc;
        cnt_r[sel_q]  <= cnt_sel + CW'(1);
      end
      if (pop_ok) begin
        head_r[sel_q] <= head_inc;
        cnt_r[sel_q]  <= cnt_sel - CW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= res;
    end
    if (issue_rd) begin
      lvl_r <= LEVEL_W'(hi_idx) + LEVEL_W'(1);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.level        = out_r.level;
  assign out_ch.result_value = out_r.result_value;

endmodule

FILE: rtl/core/multilevel_priority_fifo_unit.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_unit
// strict priority queue, one fifo per level, push / pop / peek requests
// path: command queue, result register; pop and peek also read the entry ram
// one push per cycle while results are taken; no request taken during a ram read
// a two entry command queue lets the request side run ahead of the result side
// reset: counts and pointers cleared at once, entry ram not cleared
// ----------------------------------------------------------------------------
module multilevel_priority_fifo_unit
  import mlpf_pkg::*;
#(
  parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  mlpf_in_if.sink     in_ch,
  mlpf_out_if.source  out_ch
);

  logic q_wr_valid;
  cmd_t q_wr_data;
  logic q_wr_ready;
  logic q_rd_valid;
  cmd_t q_rd_data;
  logic q_rd_ready;

  mlpf_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .in_ch      (in_ch),
    .q_wr_valid (q_wr_valid),
    .q_wr_data  (q_wr_data),
    .q_wr_ready (q_wr_ready)
  );

  mlpf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_data  (q_wr_data),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_data  (q_rd_data),
    .rd_ready (q_rd_ready)
  );

  mlpf_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_rd_valid),
    .cmd       (q_rd_data),
    .cmd_ready (q_rd_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/core/mlpf_checker.sv
// ----------------------------------------------------------------------------
// mlpf_checker
// port level checks of the multilevel priority fifo unit
// ----------------------------------------------------------------------------
module mlpf_checker
  import mlpf_pkg::*;
#(
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        out_status,
  input logic [LEVEL_W-1:0]       out_level,
  input logic signed [DATA_W-1:0] out_result_value
);

  logic [2:0] pend_r;
  logic [2:0] pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_level) && $stable(out_result_value))
    else $error("stalled result word changed");

  a_no_data_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_level == '0 && out_result_value == '0)
    else $error("failed request returned data");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level != '0 |-> out_status == ST_OK && int'(out_level) <= NUM_LEVELS)
    else $error("returned level out of range");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result word without pending request");

endmodule

bind multilevel_priority_fifo_unit mlpf_checker #(
  .NUM_LEVELS (NUM_LEVELS)
) u_mlpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_level        (out_ch.level),
  .out_result_value (out_ch.result_value)
);
